// ----- rtl/kf4_pkg.sv -----
// Shared types, constants and the microprogram of the four-state Kalman filter.
// Used by the multiplier, the divider and the top level; depends on nothing.
`default_nettype none

package kf4_pkg;

  // Fixed data format of every field and every internal value.
  localparam int KF4_DW        = 48;
  localparam int KF4_FRAC_BITS = 24;
  localparam int KF4_RW        = KF4_DW - 1;
  localparam int KF4_AW        = 6;
  localparam int KF4_PCW       = 8;

  localparam logic [KF4_DW-1:0] KF4_MAX = {1'b0, {(KF4_DW-1){1'b1}}};
  localparam logic [KF4_DW-1:0] KF4_MIN = {1'b1, {(KF4_DW-1){1'b0}}};

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_MEAS_VAR  = 3'd0;
  localparam logic [2:0] REG_PN0       = 3'd1;
  localparam logic [2:0] REG_PN1       = 3'd2;
  localparam logic [2:0] REG_PN2       = 3'd3;
  localparam logic [2:0] REG_PN3       = 3'd4;
  localparam logic [2:0] REG_INIT_DIAG = 3'd5;

  typedef struct packed {
    logic signed [KF4_DW-1:0] measurement;
    logic signed [KF4_DW-1:0] control;
  } in_data_t;

  typedef struct packed {
    logic signed [KF4_DW-1:0] est_0;
    logic signed [KF4_DW-1:0] est_1;
    logic signed [KF4_DW-1:0] est_2;
    logic signed [KF4_DW-1:0] est_3;
    logic signed [KF4_DW-1:0] gain_0;
    logic signed [KF4_DW-1:0] gain_1;
    logic signed [KF4_DW-1:0] gain_2;
    logic signed [KF4_DW-1:0] gain_3;
    logic signed [KF4_DW-1:0] innovation;
    logic        [KF4_RW-1:0] innov_var;
    logic                     saturated;
  } out_data_t;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_SFIX, OP_DIV, OP_DONE
  } op_t;

  // Operand source: top bit set selects a special value, else a scratch address.
  typedef logic [KF4_AW:0] src_t;

  typedef struct packed {
    op_t                op;
    src_t               a;
    src_t               b;
    logic [KF4_AW-1:0]  dst;
  } ins_t;

  // Special operand sources.
  localparam int SP_N = 16;
  localparam logic [3:0] SP_Z    = 4'd0;
  localparam logic [3:0] SP_U    = 4'd1;
  localparam logic [3:0] SP_R    = 4'd2;
  localparam logic [3:0] SP_Q0   = 4'd3;
  localparam logic [3:0] SP_Q1   = 4'd4;
  localparam logic [3:0] SP_Q2   = 4'd5;
  localparam logic [3:0] SP_Q3   = 4'd6;
  localparam logic [3:0] SP_C01  = 4'd7;
  localparam logic [3:0] SP_C32  = 4'd8;
  localparam logic [3:0] SP_G0   = 4'd9;
  localparam logic [3:0] SP_G1   = 4'd10;
  localparam logic [3:0] SP_G2   = 4'd11;
  localparam logic [3:0] SP_G3   = 4'd12;
  localparam logic [3:0] SP_ACC  = 4'd13;
  localparam logic [3:0] SP_ZERO = 4'd14;

  // Scratch memory map.
  localparam int KF4_MEM_DEPTH = 64;
  localparam logic [KF4_AW-1:0] A_INNOV = 6'd60;
  localparam logic [KF4_AW-1:0] A_S     = 6'd61;
  localparam logic [KF4_AW-1:0] A_T     = 6'd62;
  localparam logic [3:0] A_K_ROW = 4'd5;
  localparam logic [3:0] A_E_ROW = 4'd6;
  localparam int KF4_SWEEP_LEN = 20;

  localparam logic [KF4_PCW-1:0] PC_DONE = 8'd128;

  function automatic src_t sp(input logic [3:0] id);
    return {1'b1, 2'b00, id};
  endfunction

  function automatic src_t ms(input logic [KF4_AW-1:0] addr);
    return {1'b0, addr};
  endfunction

  function automatic logic [KF4_AW-1:0] ax(input int r);
    return 6'(r);
  endfunction

  function automatic logic [KF4_AW-1:0] ap(input int r, input int c);
    return 6'(4 + 4 * r + c);
  endfunction

  function automatic logic [KF4_AW-1:0] ak(input int r);
    return 6'(20 + r);
  endfunction

  function automatic logic [KF4_AW-1:0] ae(input int r);
    return 6'(24 + r);
  endfunction

  function automatic logic [KF4_AW-1:0] aph(input int r, input int c);
    return 6'(28 + 4 * r + c);
  endfunction

  function automatic logic [KF4_AW-1:0] aa(input int r, input int c);
    return 6'(44 + 4 * r + c);
  endfunction

  function automatic ins_t mk(input op_t op, input src_t a, input src_t b,
                              input logic [KF4_AW-1:0] dst);
    ins_t i;
    i.op  = op;
    i.a   = a;
    i.b   = b;
    i.dst = dst;
    return i;
  endfunction

  // Saturating add or subtract; the top bit of the result flags a clip.
  function automatic logic [KF4_DW:0] sat_add(input logic [KF4_DW-1:0] a,
                                              input logic [KF4_DW-1:0] b,
                                              input logic              neg_b);
    logic [KF4_DW:0] s;
    s = neg_b ? ({a[KF4_DW-1], a} - {b[KF4_DW-1], b})
              : ({a[KF4_DW-1], a} + {b[KF4_DW-1], b});
    if (s[KF4_DW] != s[KF4_DW-1]) begin
      return {1'b1, (s[KF4_DW] ? KF4_MIN : KF4_MAX)};
    end
    return {1'b0, s[KF4_DW-1:0]};
  endfunction

  // Microprogram: measurement update, then time update of state and covariance.
  function automatic ins_t prog(input logic [KF4_PCW-1:0] pc);
    ins_t i;
    int   o;
    int   r;
    int   c;
    int   k;
    i = mk(OP_DONE, sp(SP_ZERO), sp(SP_ZERO), A_T);
    o = 0;
    r = 0;
    c = 0;
    k = 0;
    if (pc == 8'd0) begin
      i = mk(OP_SFIX, ms(ap(1, 1)), sp(SP_R), A_S);
    end else if (pc == 8'd1) begin
      i = mk(OP_SUB, sp(SP_Z), ms(ax(1)), A_INNOV);
    end else if (pc < 8'd14) begin
      // Gain, then corrected estimate, one row at a time.
      o = int'(pc) - 2;
      for (int n = 0; n < 4; n++) begin
        if (o >= 3 * n) begin
          r = n;
          k = o - 3 * n;
        end
      end
      case (k)
        0:       i = mk(OP_DIV, ms(ap(r, 1)), sp(SP_ZERO), ak(r));
        1:       i = mk(OP_MUL, ms(ak(r)), ms(A_INNOV), A_T);
        default: i = mk(OP_ADD, ms(ax(r)), sp(SP_ACC), ae(r));
      endcase
    end else if (pc < 8'd46) begin
      // Corrected covariance.
      o = int'(pc) - 14;
      r = o / 8;
      c = (o / 2) % 4;
      if (o % 2 == 0) begin
        i = mk(OP_MUL, ms(ak(r)), ms(ap(1, c)), A_T);
      end else begin
        i = mk(OP_SUB, ms(ap(r, c)), sp(SP_ACC), aph(r, c));
      end
    end else if (pc < 8'd60) begin
      // State prediction.
      o = int'(pc) - 46;
      case (o)
        0:       i = mk(OP_MUL, sp(SP_C01), ms(ae(1)), A_T);
        1:       i = mk(OP_ADD, ms(ae(0)), sp(SP_ACC), A_T);
        2:       i = mk(OP_MUL, sp(SP_G0), sp(SP_U), A_T);
        3:       i = mk(OP_ADD, ms(A_T), sp(SP_ACC), ax(0));
        4:       i = mk(OP_MUL, sp(SP_G1), sp(SP_U), A_T);
        5:       i = mk(OP_ADD, ms(ae(1)), sp(SP_ACC), ax(1));
        6:       i = mk(OP_MUL, sp(SP_C01), ms(ae(3)), A_T);
        7:       i = mk(OP_ADD, ms(ae(2)), sp(SP_ACC), A_T);
        8:       i = mk(OP_MUL, sp(SP_G2), sp(SP_U), A_T);
        9:       i = mk(OP_ADD, ms(A_T), sp(SP_ACC), ax(2));
        10:      i = mk(OP_MUL, sp(SP_C32), ms(ae(2)), A_T);
        11:      i = mk(OP_ADD, ms(ae(3)), sp(SP_ACC), A_T);
        12:      i = mk(OP_MUL, sp(SP_G3), sp(SP_U), A_T);
        default: i = mk(OP_ADD, ms(A_T), sp(SP_ACC), ax(3));
      endcase
    end else if (pc < 8'd88) begin
      // Transition applied to each column of the corrected covariance.
      o = int'(pc) - 60;
      for (int n = 0; n < 4; n++) begin
        if (o >= 7 * n) begin
          c = n;
          k = o - 7 * n;
        end
      end
      case (k)
        0:       i = mk(OP_MUL, sp(SP_C01), ms(aph(1, c)), A_T);
        1:       i = mk(OP_ADD, ms(aph(0, c)), sp(SP_ACC), aa(0, c));
        2:       i = mk(OP_ADD, ms(aph(1, c)), sp(SP_ZERO), aa(1, c));
        3:       i = mk(OP_MUL, sp(SP_C01), ms(aph(3, c)), A_T);
        4:       i = mk(OP_ADD, ms(aph(2, c)), sp(SP_ACC), aa(2, c));
        5:       i = mk(OP_MUL, sp(SP_C32), ms(aph(2, c)), A_T);
        default: i = mk(OP_ADD, ms(aph(3, c)), sp(SP_ACC), aa(3, c));
      endcase
    end else if (pc < PC_DONE) begin
      // Transition applied to each row, plus the process noise.
      o = int'(pc) - 88;
      for (int n = 0; n < 4; n++) begin
        if (o >= 10 * n) begin
          r = n;
          k = o - 10 * n;
        end
      end
      case (k)
        0:       i = mk(OP_MUL, sp(SP_C01), ms(aa(r, 1)), A_T);
        1:       i = mk(OP_ADD, ms(aa(r, 0)), sp(SP_ACC), A_T);
        2:       i = mk(OP_ADD, ms(A_T), sp(SP_Q0), ap(r, 0));
        3:       i = mk(OP_ADD, ms(aa(r, 1)), sp(SP_Q1), ap(r, 1));
        4:       i = mk(OP_MUL, sp(SP_C01), ms(aa(r, 3)), A_T);
        5:       i = mk(OP_ADD, ms(aa(r, 2)), sp(SP_ACC), A_T);
        6:       i = mk(OP_ADD, ms(A_T), sp(SP_Q2), ap(r, 2));
        7:       i = mk(OP_MUL, sp(SP_C32), ms(aa(r, 2)), A_T);
        8:       i = mk(OP_ADD, ms(aa(r, 3)), sp(SP_ACC), A_T);
        default: i = mk(OP_ADD, ms(A_T), sp(SP_Q3), ap(r, 3));
      endcase
    end
    return i;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kalman_filter_4state_scalar_meas.sv -----
// Four-state Kalman filter with a scalar measurement: sequencer, scratch
// memory, configuration registers and result register. Depends on kf4_pkg,
// kf4_mul and kf4_div.
//
// Each input transfer carries a measurement of state 1 and a control value in
// Q24.24; each one yields one result transfer with the corrected estimate, the
// gain, the innovation and its variance, and a flag that is set when any value
// of the step was clipped. A small sequencer steps through a fixed program of
// 128 instructions on one shared multiplier, one saturating adder and one
// bit-serial divider, with all intermediate matrices in a 64-entry scratch
// memory. The input is not ready while an item is in work. After reset, and
// after every write of init_cov_diag, a pass loads the state and the
// covariance; inputs wait during it. A finished result stays in the output
// register until taken, and the next input is accepted meanwhile.
`default_nettype none

module kalman_filter_4state_scalar_meas import kf4_pkg::*; #(
  parameter int FRAC_BITS = KF4_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_data_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_data_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int W = KF4_DW;

  // Fixed matrix entries, rounded to FRAC_BITS and clipped to the positive range.
  localparam logic [63:0] POSMAX64 = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [63:0] C01_M = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] C32_M =
    ((64'd9637185 << FRAC_BITS) + 64'd50000000000) / 64'd100000000000;
  localparam logic [63:0] G0_M = ((64'd244 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] G1_M = ((64'd4888 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] G2_M = ((64'd73529 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] G3_M = ((64'd1470588 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [W-1:0] C01_V = W'((C01_M > POSMAX64) ? POSMAX64 : C01_M);
  localparam logic [W-1:0] C32_V = W'(0) - W'((C32_M > POSMAX64) ? POSMAX64 : C32_M);
  localparam logic [W-1:0] G0_V  = W'(0) - W'((G0_M > POSMAX64) ? POSMAX64 : G0_M);
  localparam logic [W-1:0] G1_V  = W'(0) - W'((G1_M > POSMAX64) ? POSMAX64 : G1_M);
  localparam logic [W-1:0] G2_V  = W'((G2_M > POSMAX64) ? POSMAX64 : G2_M);
  localparam logic [W-1:0] G3_V  = W'((G3_M > POSMAX64) ? POSMAX64 : G3_M);

  state_t state_r, state_nxt;
  logic [KF4_PCW-1:0] pc_r, pc_nxt;
  logic [4:0]         sweep_r;
  logic [W-1:0]       z_r;
  logic [W-1:0]       u_r;
  logic [W-1:0]       acc_r;
  logic [KF4_RW-1:0]  s_r;
  logic               sat_r;
  logic [W-1:0]       est_r [4];
  logic [W-1:0]       gain_r [4];
  logic [W-1:0]       innov_r;
  out_data_t          out_r;
  logic               out_valid_r;

  logic [KF4_RW-1:0]  meas_var_r;
  logic [KF4_RW-1:0]  pn_r [4];
  logic [KF4_RW-1:0]  diag_r;

  logic [W-1:0]       mem [KF4_MEM_DEPTH];
  logic [W-1:0]       rda_r;
  logic [W-1:0]       rdb_r;

  ins_t               ins;
  logic [W-1:0]       spv [SP_N];
  logic [W-1:0]       opa;
  logic [W-1:0]       opb;
  logic [W:0]         add_res;
  logic [W-1:0]       alu_val;
  logic               alu_sat;

  logic               cfg_wr;
  logic               diag_wr;
  logic               in_xfer;
  logic               out_free;
  logic [4:0]         sweep_off;

  logic               mem_we;
  logic [KF4_AW-1:0]  mem_waddr;
  logic [W-1:0]       mem_wdata;
  logic               mul_start;
  logic               div_start;
  logic               mul_done;
  logic               div_done;
  logic [W-1:0]       mul_res;
  logic [W-1:0]       div_res;
  logic               mul_sat;
  logic               div_sat;

  // Handshakes.
  assign cfg_wr   = psel & penable & pwrite;
  assign diag_wr  = cfg_wr && (paddr[5:3] == REG_INIT_DIAG);
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign pready   = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_var_r <= KF4_RW'(64'd1677721600);
      pn_r[0]    <= KF4_RW'(64'd70);
      pn_r[1]    <= KF4_RW'(64'd2796);
      pn_r[2]    <= KF4_RW'(64'd83886);
      pn_r[3]    <= KF4_RW'(64'd1677722);
      diag_r     <= KF4_RW'(64'd16777216000);
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_MEAS_VAR:  meas_var_r <= pwdata[KF4_RW-1:0];
        REG_PN0:       pn_r[0]    <= pwdata[KF4_RW-1:0];
        REG_PN1:       pn_r[1]    <= pwdata[KF4_RW-1:0];
        REG_PN2:       pn_r[2]    <= pwdata[KF4_RW-1:0];
        REG_PN3:       pn_r[3]    <= pwdata[KF4_RW-1:0];
        REG_INIT_DIAG: diag_r     <= pwdata[KF4_RW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[5:3])
      REG_MEAS_VAR:  prdata = 64'(meas_var_r);
      REG_PN0:       prdata = 64'(pn_r[0]);
      REG_PN1:       prdata = 64'(pn_r[1]);
      REG_PN2:       prdata = 64'(pn_r[2]);
      REG_PN3:       prdata = 64'(pn_r[3]);
      REG_INIT_DIAG: prdata = 64'(diag_r);
      default:       prdata = 64'd0;
    endcase
  end

  // Current instruction and its operands.
  assign ins = prog(pc_r);

  always_comb begin
    for (int i = 0; i < SP_N; i++) begin
      spv[i] = '0;
    end
    spv[SP_Z]   = z_r;
    spv[SP_U]   = u_r;
    spv[SP_R]   = {1'b0, meas_var_r};
    spv[SP_Q0]  = {1'b0, pn_r[0]};
    spv[SP_Q1]  = {1'b0, pn_r[1]};
    spv[SP_Q2]  = {1'b0, pn_r[2]};
    spv[SP_Q3]  = {1'b0, pn_r[3]};
    spv[SP_C01] = C01_V;
    spv[SP_C32] = C32_V;
    spv[SP_G0]  = G0_V;
    spv[SP_G1]  = G1_V;
    spv[SP_G2]  = G2_V;
    spv[SP_G3]  = G3_V;
    spv[SP_ACC] = acc_r;
  end

  assign opa = ins.a[KF4_AW] ? spv[ins.a[3:0]] : rda_r;
  assign opb = ins.b[KF4_AW] ? spv[ins.b[3:0]] : rdb_r;

  // Saturating adder; the variance step also forces a floor of one.
  always_comb begin
    add_res = sat_add(opa, opb, ins.op == OP_SUB);
    alu_val = add_res[W-1:0];
    alu_sat = add_res[W];
    if (ins.op == OP_SFIX && (alu_val[W-1] || alu_val == '0)) begin
      alu_val = W'(1);
      alu_sat = 1'b1;
    end
  end

  // Shared arithmetic units.
  kf4_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (opa),
    .b    (opb),
    .done (mul_done),
    .res  (mul_res),
    .sat  (mul_sat)
  );

  kf4_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (opa),
    .den  (s_r),
    .done (div_done),
    .res  (div_res),
    .sat  (div_sat)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      ST_INIT: begin
        if (sweep_r == 5'(KF4_SWEEP_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_FETCH;
          pc_nxt    = '0;
        end
      end
      ST_FETCH: begin
        state_nxt = (ins.op == OP_DONE) ? ST_DONE : ST_EXEC;
      end
      ST_EXEC: begin
        if (ins.op == OP_MUL || ins.op == OP_DIV) begin
          state_nxt = ST_WAIT;
        end else begin
          state_nxt = ST_FETCH;
          pc_nxt    = pc_r + KF4_PCW'(1);
        end
      end
      ST_WAIT: begin
        if ((ins.op == OP_MUL && mul_done) || (ins.op == OP_DIV && div_done)) begin
          state_nxt = ST_FETCH;
          pc_nxt    = pc_r + KF4_PCW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (diag_wr) begin
      state_nxt = ST_INIT;
    end
  end

  // Sequencer outputs: scratch write port and unit starts.
  assign sweep_off = sweep_r - 5'd4;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ins.dst;
    mem_wdata = alu_val;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = KF4_AW'(sweep_r);
        if (sweep_r >= 5'd4 && sweep_off[3:2] == sweep_off[1:0]) begin
          mem_wdata = {1'b0, diag_r};
        end else begin
          mem_wdata = '0;
        end
      end
      ST_EXEC: begin
        case (ins.op)
          OP_MUL:  mul_start = 1'b1;
          OP_DIV:  div_start = 1'b1;
          OP_ADD, OP_SUB, OP_SFIX: mem_we = 1'b1;
          default: ;
        endcase
      end
      ST_WAIT: begin
        mem_wdata = div_res;
        mem_we    = (ins.op == OP_DIV) && div_done;
      end
      default: ;
    endcase
  end

  // Scratch memory with registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rda_r <= mem[ins.a[KF4_AW-1:0]];
    rdb_r <= mem[ins.b[KF4_AW-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      pc_r        <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      if (diag_wr) begin
        sweep_r <= '0;
      end else if (state_r == ST_INIT) begin
        sweep_r <= sweep_r + 5'd1;
      end
      if (in_xfer) begin
        sat_r <= 1'b0;
      end else if (state_r == ST_EXEC && mem_we) begin
        sat_r <= sat_r | alu_sat;
      end else if (state_r == ST_WAIT && ins.op == OP_MUL && mul_done) begin
        sat_r <= sat_r | mul_sat;
      end else if (state_r == ST_WAIT && ins.op == OP_DIV && div_done) begin
        sat_r <= sat_r | div_sat;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: inputs, accumulator and the fields of the result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      z_r <= in_data.measurement;
      u_r <= in_data.control;
    end
    if (state_r == ST_WAIT && ins.op == OP_MUL && mul_done) begin
      acc_r <= mul_res;
    end
    if (mem_we && state_r != ST_INIT) begin
      if (mem_waddr[5:2] == A_K_ROW) begin
        gain_r[mem_waddr[1:0]] <= mem_wdata;
      end
      if (mem_waddr[5:2] == A_E_ROW) begin
        est_r[mem_waddr[1:0]] <= mem_wdata;
      end
      if (mem_waddr == A_INNOV) begin
        innov_r <= mem_wdata;
      end
      if (mem_waddr == A_S) begin
        s_r <= mem_wdata[KF4_RW-1:0];
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_r.est_0      <= est_r[0];
      out_r.est_1      <= est_r[1];
      out_r.est_2      <= est_r[2];
      out_r.est_3      <= est_r[3];
      out_r.gain_0     <= gain_r[0];
      out_r.gain_1     <= gain_r[1];
      out_r.gain_2     <= gain_r[2];
      out_r.gain_3     <= gain_r[3];
      out_r.innovation <= innov_r;
      out_r.innov_var  <= s_r;
      out_r.saturated  <= sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A finished item always reaches the output register once it is free.
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_valid_r)
    else $error("finished result was not moved to the output register");

  // The program counter never runs past its final instruction.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_DONE)
    else $error("program counter out of range");

  // A restart of the covariance takes away input ready once the write is seen.
  a_restart_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    diag_wr |=> !in_ready)
    else $error("input accepted during covariance reload");

  // The innovation variance of any delivered result is at least one.
  a_var_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.innov_var != '0))
    else $error("zero innovation variance delivered");

endmodule

`default_nettype wire

// ----- rtl/kf4_mul.sv -----
// Multi-cycle fixed-point multiplier: four half-width partial products, then
// rounding to nearest (ties away from zero) and clipping. Depends on kf4_pkg.
`default_nettype none

module kf4_mul import kf4_pkg::*; #(
  parameter int FRAC_BITS = KF4_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [KF4_DW-1:0] a,
  input  logic signed [KF4_DW-1:0] b,
  output logic                     done,
  output logic signed [KF4_DW-1:0] res,
  output logic                     sat
);

  localparam int W  = KF4_DW;
  localparam int H  = (W + 1) / 2;
  localparam int PW = 2 * W;

  logic          busy_r;
  logic          done_r;
  logic [2:0]    cnt_r;
  logic          neg_r;
  logic [W-1:0]  ua_r;
  logic [W-1:0]  ub_r;
  logic [2*H-1:0] pp_r;
  logic [1:0]    shc_r;
  logic [PW-1:0] acc_r;
  logic [W-1:0]  res_r;
  logic          sat_r;

  logic [PW:0]   rnd_sum;
  logic [PW:0]   rnd_mag;
  logic [PW:0]   lim;
  logic          ovf;
  logic [W-1:0]  rnd_val;

  function automatic logic [H-1:0] half(input logic [W-1:0] v, input logic hi);
    return hi ? H'(v >> H) : v[H-1:0];
  endfunction

  // Control: one start, the working steps, one done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Rounding and clipping of the accumulated magnitude.
  always_comb begin
    rnd_sum = {1'b0, acc_r} + ((PW+1)'(1) << (FRAC_BITS - 1));
    rnd_mag = rnd_sum >> FRAC_BITS;
    lim     = (PW+1)'(1) << (W - 1);
    ovf     = neg_r ? (rnd_mag > lim) : (rnd_mag >= lim);
    if (ovf) begin
      rnd_val = neg_r ? KF4_MIN : KF4_MAX;
    end else begin
      rnd_val = neg_r ? (W'(0) - rnd_mag[W-1:0]) : rnd_mag[W-1:0];
    end
  end

  // Datapath: each partial product is registered and accumulated in the next cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      ua_r  <= a[W-1] ? (W'(0) - a) : a;
      ub_r  <= b[W-1] ? (W'(0) - b) : b;
      neg_r <= a[W-1] ^ b[W-1];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        pp_r  <= half(ua_r, cnt_r[1]) * half(ub_r, cnt_r[0]);
        shc_r <= 2'(cnt_r[1]) + 2'(cnt_r[0]);
      end
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
        acc_r <= acc_r + (PW'(pp_r) << (H * int'(shc_r)));
      end
      if (cnt_r == 3'd5) begin
        res_r <= rnd_val;
        sat_r <= ovf;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign sat  = sat_r;

endmodule

`default_nettype wire

// ----- rtl/kf4_div.sv -----
// Bit-serial restoring divider for the gain: num * 2^FRAC_BITS / den,
// rounded to nearest (ties away from zero) and clipped. Depends on kf4_pkg.
`default_nettype none

module kf4_div import kf4_pkg::*; #(
  parameter int FRAC_BITS = KF4_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [KF4_DW-1:0] num,
  input  logic        [KF4_RW-1:0] den,
  output logic                     done,
  output logic signed [KF4_DW-1:0] res,
  output logic                     sat
);

  localparam int W  = KF4_DW;
  localparam int N  = W + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic [N-1:0]  dvd_r;
  logic [N-1:0]  q_r;
  logic [W-1:0]  rem_r;
  logic [W-2:0]  den_r;
  logic [W-1:0]  res_r;
  logic          sat_r;

  logic [W-1:0]  num_mag;
  logic [W-1:0]  rem_sh;
  logic          ge;
  logic          rnd;
  logic [N:0]    q_rnd;
  logic [N:0]    lim;
  logic          ovf;
  logic [W-1:0]  fin_val;

  // Control: N shift-subtract steps and one rounding step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(N)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Magnitude of the numerator at the data width.
  assign num_mag = num[W-1] ? (W'(0) - num) : num;

  // One quotient bit per step, then round and clip.
  always_comb begin
    rem_sh = {rem_r[W-2:0], dvd_r[N-1]};
    ge     = rem_sh >= {1'b0, den_r};
    rnd    = {rem_r, 1'b0} >= {2'b00, den_r};
    q_rnd  = {1'b0, q_r} + (N+1)'(rnd);
    lim    = (N+1)'(1) << (W - 1);
    ovf    = neg_r ? (q_rnd > lim) : (q_rnd >= lim);
    if (ovf) begin
      fin_val = neg_r ? KF4_MIN : KF4_MAX;
    end else begin
      fin_val = neg_r ? (W'(0) - q_rnd[W-1:0]) : q_rnd[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num_mag, {FRAC_BITS{1'b0}}};
      q_r   <= '0;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[W-1];
    end else if (busy_r) begin
      if (cnt_r < CW'(N)) begin
        rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        q_r   <= {q_r[N-2:0], ge};
        dvd_r <= dvd_r << 1;
      end else begin
        res_r <= fin_val;
        sat_r <= ovf;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign sat  = sat_r;

endmodule

`default_nettype wire

// ----- test/kalman_filter_4state_scalar_meas_checker.sv -----
// Checker for the four-state Kalman filter: it follows the configuration writes,
// predicts each result from the input transfers and compares the result transfers.
// Depends on kf4_pkg for the payload types and register indexes.
`timescale 1ns / 1ps

module kalman_filter_4state_scalar_meas_checker import kf4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_data_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_data_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          errors,
  output int          pending,
  output int          checked,
  output int          sat_seen
);

  typedef logic signed [127:0] wide_t;
  typedef logic signed [KF4_DW-1:0] val_t;
  typedef val_t vec_t [4];

  // Filter state and registers as the block should hold them.
  val_t         x_pred [4];
  val_t         p_pred [4][4];
  logic [46:0]  cfg_reg [6];
  logic         clipped;
  out_data_t    expected_results [$];

  // Clip to the 48-bit range and note that a clip happened.
  function automatic val_t clamp(wide_t v);
    if (v > wide_t'(KF4_MAX)) begin
      clipped = 1'b1;
      return KF4_MAX;
    end
    if (v < -(wide_t'(1) <<< 47)) begin
      clipped = 1'b1;
      return KF4_MIN;
    end
    return val_t'(v);
  endfunction

  function automatic val_t add_c(val_t a, val_t b);
    return clamp(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic val_t sub_c(val_t a, val_t b);
    return clamp(wide_t'(a) - wide_t'(b));
  endfunction

  // Product rounded on the magnitude, so ties go away from zero.
  function automatic val_t mul_c(val_t a, val_t b);
    wide_t ma;
    wide_t mb;
    wide_t mag;
    ma  = a < 0 ? -wide_t'(a) : wide_t'(a);
    mb  = b < 0 ? -wide_t'(b) : wide_t'(b);
    mag = (ma * mb + (wide_t'(1) <<< (KF4_FRAC_BITS - 1))) >>> KF4_FRAC_BITS;
    return clamp(((a < 0) != (b < 0)) ? -mag : mag);
  endfunction

  // Quotient num * 2^24 / s, rounded to nearest with ties away from zero.
  function automatic val_t div_c(val_t num, val_t s);
    wide_t mag;
    wide_t q;
    wide_t r;
    mag = (num < 0 ? -wide_t'(num) : wide_t'(num)) <<< KF4_FRAC_BITS;
    q   = mag / wide_t'(s);
    r   = mag % wide_t'(s);
    if (r >= wide_t'(s) - r) q = q + 1;
    return clamp(num < 0 ? -q : q);
  endfunction

  function automatic val_t coef(longint unsigned num, longint unsigned den, bit neg);
    wide_t v;
    v = ((wide_t'(num) <<< KF4_FRAC_BITS) + wide_t'(den / 2)) / wide_t'(den);
    if (v > wide_t'(KF4_MAX)) v = wide_t'(KF4_MAX);
    return val_t'(neg ? -v : v);
  endfunction

  // Transition matrix applied to a vector.
  function automatic vec_t transition(vec_t v);
    vec_t o;
    val_t c01;
    val_t c32;
    c01  = coef(64'd1, 64'd10, 1'b0);
    c32  = coef(64'd9637185, 64'd100000000000, 1'b1);
    o[0] = add_c(v[0], mul_c(c01, v[1]));
    o[1] = v[1];
    o[2] = add_c(v[2], mul_c(c01, v[3]));
    o[3] = add_c(mul_c(c32, v[2]), v[3]);
    return o;
  endfunction

  function automatic void restart_filter();
    for (int r = 0; r < 4; r++) begin
      x_pred[r] = '0;
      for (int c = 0; c < 4; c++) begin
        p_pred[r][c] = (r == c) ? val_t'({1'b0, cfg_reg[REG_INIT_DIAG]}) : '0;
      end
    end
  endfunction

  // One measurement update and one time update; returns the result it yields.
  function automatic out_data_t filter_step(in_data_t d);
    out_data_t res;
    val_t      g [4];
    val_t      s;
    val_t      innov;
    val_t      k [4];
    vec_t      e;
    vec_t      t;
    vec_t      col;
    val_t      ph [4][4];
    val_t      a [4][4];
    g[0]    = coef(244, 10000, 1'b1);
    g[1]    = coef(4888, 10000, 1'b1);
    g[2]    = coef(73529, 10000, 1'b0);
    g[3]    = coef(1470588, 10000, 1'b0);
    clipped = 1'b0;
    s = add_c(p_pred[1][1], val_t'({1'b0, cfg_reg[REG_MEAS_VAR]}));
    if (s < 1) begin
      s       = 1;
      clipped = 1'b1;
    end
    innov = sub_c(d.measurement, x_pred[1]);
    for (int r = 0; r < 4; r++) begin
      k[r] = div_c(p_pred[r][1], s);
      e[r] = add_c(x_pred[r], mul_c(k[r], innov));
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) ph[r][c] = sub_c(p_pred[r][c], mul_c(k[r], p_pred[1][c]));
    end
    // Time update of state, then covariance as F * Ph * F' plus noise rows.
    t = transition(e);
    for (int r = 0; r < 4; r++) x_pred[r] = add_c(t[r], mul_c(g[r], d.control));
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = ph[r][c];
      t = transition(col);
      for (int r = 0; r < 4; r++) a[r][c] = t[r];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) col[c] = a[r][c];
      t = transition(col);
      for (int c = 0; c < 4; c++) p_pred[r][c] = add_c(t[c], val_t'({1'b0, cfg_reg[1 + c]}));
    end
    res.est_0      = e[0];
    res.est_1      = e[1];
    res.est_2      = e[2];
    res.est_3      = e[3];
    res.gain_0     = k[0];
    res.gain_1     = k[1];
    res.gain_2     = k[2];
    res.gain_3     = k[3];
    res.innovation = innov;
    res.innov_var  = s[KF4_RW-1:0];
    res.saturated  = clipped;
    return res;
  endfunction

  function automatic void compare_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Follow register writes, predict on input transfers, check output transfers.
  always @(posedge clk) begin
    out_data_t want;
    if (!rst_n) begin
      cfg_reg[REG_MEAS_VAR]  <= 47'd1677721600;
      cfg_reg[REG_PN0]       <= 47'd70;
      cfg_reg[REG_PN1]       <= 47'd2796;
      cfg_reg[REG_PN2]       <= 47'd83886;
      cfg_reg[REG_PN3]       <= 47'd1677722;
      cfg_reg[REG_INIT_DIAG] <= 47'd16777216000;
      for (int r = 0; r < 4; r++) begin
        x_pred[r] <= '0;
        for (int c = 0; c < 4; c++) p_pred[r][c] <= (r == c) ? 48'sd16777216000 : '0;
      end
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[5:3] <= REG_INIT_DIAG) begin
        cfg_reg[paddr[5:3]] = pwdata[46:0];
        if (paddr[5:3] == REG_INIT_DIAG) restart_filter();
      end
      if (in_valid && in_ready) begin
        want = filter_step(in_data);
        expected_results.push_back(want);
        if (want.saturated) sat_seen++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no result expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("est_0", want.est_0, out_data.est_0);
          compare_field("est_1", want.est_1, out_data.est_1);
          compare_field("est_2", want.est_2, out_data.est_2);
          compare_field("est_3", want.est_3, out_data.est_3);
          compare_field("gain_0", want.gain_0, out_data.gain_0);
          compare_field("gain_1", want.gain_1, out_data.gain_1);
          compare_field("gain_2", want.gain_2, out_data.gain_2);
          compare_field("gain_3", want.gain_3, out_data.gain_3);
          compare_field("innovation", want.innovation, out_data.innovation);
          compare_field("innov_var", 48'(want.innov_var), 48'(out_data.innov_var));
          compare_field("saturated", 48'(want.saturated), 48'(out_data.saturated));
          checked++;
        end
      end
    end
    pending = expected_results.size();
  end

  initial begin
    errors   = 0;
    pending  = 0;
    checked  = 0;
    sat_seen = 0;
  end

endmodule

// ----- test/kalman_filter_4state_scalar_meas_tb.sv -----
// Top of the Kalman filter testbench: clock, reset, register writes, input
// stimulus and the receiver's stall pattern. Depends on kf4_pkg, the block
// and kalman_filter_4state_scalar_meas_checker.
`timescale 1ns / 1ps

module kalman_filter_4state_scalar_meas_tb import kf4_pkg::*;;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_data_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_data_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          checked;
  int          sat_seen;
  int          burst_left;
  int          stall_left;
  int          stall_mode;

  kalman_filter_4state_scalar_meas u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  kalman_filter_4state_scalar_meas_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending), .checked(checked), .sat_seen(sat_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stretches of always ready, random ready, and long stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      stall_mode <= 0;
    end else if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(1, 300);
      out_ready  <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= 1'b0;
      endcase
    end
  end

  // Value spread: mostly moderate, some full range, a few extremes.
  function automatic logic [47:0] pick_value();
    logic [47:0] v;
    int          sel;
    v   = 48'({$urandom, $urandom});
    sel = $urandom_range(0, 99);
    if (sel < 80) return 48'($signed(v) >>> $urandom_range(10, 30));
    if (sel < 92) return v;
    case ($urandom_range(0, 4))
      0:       return KF4_MAX;
      1:       return KF4_MIN;
      2:       return '0;
      3:       return 48'd1;
      default: return '1;
    endcase
  endfunction

  function automatic logic [46:0] pick_reg(int setting);
    logic [46:0] v;
    v = 47'({$urandom, $urandom});
    case (setting)
      1:       return 47'd0;
      2:       return '1;
      default: return $urandom_range(0, 3) == 0 ? v : v >> $urandom_range(8, 40);
    endcase
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [46:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {17'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One input transfer; valid stays up into the next item within a burst.
  task automatic send_item(logic [47:0] z, logic [47:0] u);
    in_valid <= 1'b1;
    in_data  <= {z, u};
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(0, 12);
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    logic [46:0] mv;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of both fields on the reset settings.
    send_item('0, '0);
    send_item(KF4_MAX, '0);
    send_item(KF4_MIN, '0);
    send_item('0, KF4_MAX);
    send_item('0, KF4_MIN);
    send_item(KF4_MAX, KF4_MAX);
    send_item(KF4_MIN, KF4_MIN);
    send_item(48'd1, '1);
    send_item('1, 48'd1);
    send_item(48'h000001000000, 48'h000000100000);
    send_item(48'hFFFFFF000000, 48'hFFFFFFF00000);
    send_item(KF4_MAX, KF4_MIN);
    wait_idle();

    // Phases over register settings; the first two are the low and high extremes.
    for (int ph = 1; ph <= PHASES; ph++) begin
      mv = pick_reg(ph);
      if (mv == 0) mv = 47'd1;
      reg_write(REG_MEAS_VAR, mv);
      reg_write(REG_PN0, pick_reg(ph));
      reg_write(REG_PN1, pick_reg(ph));
      reg_write(REG_PN2, pick_reg(ph));
      reg_write(REG_PN3, pick_reg(ph));
      // Writes past the last register must change nothing.
      if (ph % 3 == 0) begin
        reg_write(3'd6, '1);
        reg_write(3'd7, '1);
      end
      reg_write(REG_INIT_DIAG, pick_reg(ph));
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(pick_value(), pick_value());
      wait_idle();
    end
    repeat (1000) @(posedge clk);

    $display("Checked %0d results over %0d register settings, %0d of them with a clip.",
             checked, PHASES + 1, sat_seen);
    if (errors == 0 && pending == 0) begin
      $display("kalman_filter_4state_scalar_meas_tb: PASS");
    end else begin
      $display("kalman_filter_4state_scalar_meas_tb: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200ms;
    $display("Run timed out with %0d results outstanding.", pending);
    $display("kalman_filter_4state_scalar_meas_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/kf4_pkg.sv
rtl/kf4_mul.sv
rtl/kf4_div.sv
rtl/kalman_filter_4state_scalar_meas.sv
test/kalman_filter_4state_scalar_meas_checker.sv
test/kalman_filter_4state_scalar_meas_tb.sv
